// ===== design/i2cmws_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C write master with scan: shared definitions
// Item kinds, controller modes, bus phases and scan address constants.
// ----------------------------------------------------------------------------
package i2cmws_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_BEGIN = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_SCAN  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WRITE = 3'b010,
        MODE_SCAN  = 3'b100
    } mode_t;

    typedef enum logic [13:0] {
        PH_START1    = 14'b00000000000001,
        PH_START2    = 14'b00000000000010,
        PH_BIT_LO    = 14'b00000000000100,
        PH_BIT_HI    = 14'b00000000001000,
        PH_ACK_LO    = 14'b00000000010000,
        PH_ACK_HI    = 14'b00000000100000,
        PH_ACK_READ  = 14'b00000001000000,
        PH_WAIT      = 14'b00000010000000,
        PH_STOP2     = 14'b00000100000000,
        PH_STOP3     = 14'b00001000000000,
        PH_FINISH    = 14'b00010000000000,
        PH_SETTLE    = 14'b00100000000000,
        PH_IDLE      = 14'b01000000000000,
        PH_IDLE_READ = 14'b10000000000000
    } phase_t;

    localparam logic [6:0] FIRST_PROBE  = 7'h3C;
    localparam logic [6:0] SECOND_PROBE = 7'h3D;
    localparam logic [6:0] RANGE_LOW    = 7'h08;
    localparam logic [6:0] RANGE_HIGH   = 7'h77;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== design/i2c_master_write_with_scan_unit.sv =====
// ----------------------------------------------------------------------------
// I2C write master with scan
// Open-drain write-only I2C master stepped by half-period ticks, with a scan.
// ----------------------------------------------------------------------------
// Usage:
// Every transaction on the s_ channel is one item: a half-period tick carrying
// the sensed pin levels, a begin-write command, a data byte, or a scan start.
// Every item yields exactly one result transaction on the m_ channel, holding
// the drive-low enables for both pins and the status of the controller.
// An accepted item is captured in an input register and processed once the
// output register is free or being taken: the controller state is updated and
// the result is written into the output register. One item per clock is
// sustained when the receiver keeps m_ready high.
// Both stages are single registers, so the block keeps accepting while a
// result waits; if the receiver stalls, the input register fills and s_ready
// drops until the result is taken. Results are never dropped or reordered.
// A synchronous active-low reset releases both pins, returns the controller
// to idle with the default pin mapping (data on pin 1) and empties both stages.
// ----------------------------------------------------------------------------
module i2c_master_write_with_scan_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [6:0]  s_address,
    input  logic [15:0] s_byte_count,
    input  logic [7:0]  s_data_byte,
    input  logic        s_pin0_level,
    input  logic        s_pin1_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pin0_drive_low,
    output logic        m_pin1_drive_low,
    output logic        m_busy_res,
    output logic        m_want_byte,
    output logic        m_done_res,
    output logic        m_write_ok,
    output logic [31:0] m_nack_total,
    output logic [6:0]  m_found_address,
    output logic        m_pins_swapped,
    output logic        m_data_idle_high,
    output logic        m_clock_idle_high
);

    // Input register.
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_kind_reg;
    logic [6:0]  in_address_reg;
    logic [15:0] in_count_reg;
    logic [7:0]  in_data_reg;
    logic        in_pin0_reg;
    logic        in_pin1_reg;

    // Controller state.
    i2cmws_pkg::mode_t  mode_reg, mode_next;
    i2cmws_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        all_acked_reg, all_acked_next;
    logic [7:0]  holding_byte_reg, holding_byte_next;
    logic        holding_valid_reg, holding_valid_next;
    logic        data_on_pin1_reg, data_on_pin1_next;
    logic [31:0] fail_count_reg, fail_count_next;
    logic [6:0]  scan_addr_reg, scan_addr_next;
    logic        scan_pass_reg, scan_pass_next;
    logic [6:0]  rf_addr_reg, rf_addr_next;
    logic        rf_swapped_reg, rf_swapped_next;
    logic        rf_data_idle_reg, rf_data_idle_next;
    logic        rf_clock_idle_reg, rf_clock_idle_next;
    logic        sda_low_reg, sda_low_next;
    logic        scl_low_reg, scl_low_next;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic        out_pin0_reg, out_pin1_reg, out_busy_reg, out_want_reg;
    logic        out_done_reg, out_ok_reg;

    logic        s_accept;
    logic        process;
    logic        done;
    logic        ok;
    logic        do_load;
    logic        dsense;
    logic        csense;
    logic [6:0]  addr_inc;
    logic [6:0]  addr_step;
    logic [6:0]  addr_cand;
    logic        addr_more;

    assign process  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || process;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (process) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Scan address sequence: the two preferred probes first, then the
    // general range with those two skipped.
    always_comb begin
        addr_inc  = scan_addr_reg + 7'd1;
        addr_cand = (addr_inc == i2cmws_pkg::FIRST_PROBE) ?
                    (i2cmws_pkg::SECOND_PROBE + 7'd1) : addr_inc;
        if (scan_addr_reg == i2cmws_pkg::FIRST_PROBE) begin
            addr_step = i2cmws_pkg::SECOND_PROBE;
            addr_more = 1'b1;
        end else if (scan_addr_reg == i2cmws_pkg::SECOND_PROBE) begin
            addr_step = i2cmws_pkg::RANGE_LOW;
            addr_more = 1'b1;
        end else begin
            addr_step = addr_cand;
            addr_more = (addr_cand <= i2cmws_pkg::RANGE_HIGH);
        end
    end

    always_comb begin
        mode_next          = mode_reg;
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        shift_next         = shift_reg;
        bytes_left_next    = bytes_left_reg;
        all_acked_next     = all_acked_reg;
        holding_byte_next  = holding_byte_reg;
        holding_valid_next = holding_valid_reg;
        data_on_pin1_next  = data_on_pin1_reg;
        fail_count_next    = fail_count_reg;
        scan_addr_next     = scan_addr_reg;
        scan_pass_next     = scan_pass_reg;
        rf_addr_next       = rf_addr_reg;
        rf_swapped_next    = rf_swapped_reg;
        rf_data_idle_next  = rf_data_idle_reg;
        rf_clock_idle_next = rf_clock_idle_reg;
        sda_low_next       = sda_low_reg;
        scl_low_next       = scl_low_reg;
        done               = 1'b0;
        ok                 = 1'b0;
        do_load            = 1'b0;
        dsense = data_on_pin1_reg ? in_pin1_reg : in_pin0_reg;
        csense = data_on_pin1_reg ? in_pin0_reg : in_pin1_reg;

        case (i2cmws_pkg::kind_t'(in_kind_reg))
            i2cmws_pkg::KIND_TICK: begin
                case (mode_reg)
                    i2cmws_pkg::MODE_IDLE: begin
                        sda_low_next = 1'b0;
                        scl_low_next = 1'b0;
                    end
                    i2cmws_pkg::MODE_WRITE, i2cmws_pkg::MODE_SCAN: begin
                        case (phase_reg)
                            i2cmws_pkg::PH_START1: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_START2;
                            end
                            i2cmws_pkg::PH_START2: begin
                                sda_low_next = 1'b1;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_BIT_LO;
                            end
                            i2cmws_pkg::PH_BIT_LO: begin
                                sda_low_next = ~shift_reg[7];
                                scl_low_next = 1'b1;
                                phase_next   = i2cmws_pkg::PH_BIT_HI;
                            end
                            i2cmws_pkg::PH_BIT_HI: begin
                                sda_low_next   = ~shift_reg[7];
                                scl_low_next   = 1'b0;
                                shift_next     = {shift_reg[6:0], 1'b0};
                                bit_index_next = bit_index_reg + 4'd1;
                                phase_next = (bit_index_next >= i2cmws_pkg::BITS_PER_BYTE) ?
                                             i2cmws_pkg::PH_ACK_LO : i2cmws_pkg::PH_BIT_LO;
                            end
                            i2cmws_pkg::PH_ACK_LO: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b1;
                                phase_next   = i2cmws_pkg::PH_ACK_HI;
                            end
                            i2cmws_pkg::PH_ACK_HI: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_ACK_READ;
                            end
                            i2cmws_pkg::PH_ACK_READ: begin
                                if (mode_reg == i2cmws_pkg::MODE_WRITE) begin
                                    all_acked_next = all_acked_reg & ~dsense;
                                end else begin
                                    all_acked_next = ~dsense;
                                end
                                if (mode_reg == i2cmws_pkg::MODE_WRITE &&
                                    bytes_left_reg != 16'd0) begin
                                    do_load = 1'b1;
                                end else begin
                                    sda_low_next = 1'b1;
                                    scl_low_next = 1'b1;
                                    phase_next   = i2cmws_pkg::PH_STOP2;
                                end
                            end
                            i2cmws_pkg::PH_WAIT: begin
                                if (mode_reg == i2cmws_pkg::MODE_WRITE &&
                                    bytes_left_reg != 16'd0) begin
                                    do_load = 1'b1;
                                end else begin
                                    sda_low_next = 1'b1;
                                    scl_low_next = 1'b1;
                                    phase_next   = i2cmws_pkg::PH_STOP2;
                                end
                            end
                            i2cmws_pkg::PH_STOP2: begin
                                sda_low_next = 1'b1;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_STOP3;
                            end
                            i2cmws_pkg::PH_STOP3: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_FINISH;
                            end
                            i2cmws_pkg::PH_FINISH: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                                if (mode_reg == i2cmws_pkg::MODE_WRITE) begin
                                    done = 1'b1;
                                    ok   = all_acked_reg;
                                    if (!all_acked_reg) begin
                                        fail_count_next = fail_count_reg + 32'd1;
                                    end
                                    mode_next  = i2cmws_pkg::MODE_IDLE;
                                    phase_next = i2cmws_pkg::PH_START1;
                                end else if (all_acked_reg) begin
                                    // A device answered: record it and stop.
                                    done            = 1'b1;
                                    rf_addr_next    = scan_addr_reg;
                                    rf_swapped_next = data_on_pin1_reg;
                                    fail_count_next = 32'd0;
                                    mode_next       = i2cmws_pkg::MODE_IDLE;
                                    phase_next      = i2cmws_pkg::PH_START1;
                                end else if (addr_more) begin
                                    scan_addr_next = addr_step;
                                    shift_next     = {addr_step, 1'b0};
                                    bit_index_next = 4'd0;
                                    phase_next     = i2cmws_pkg::PH_START2;
                                end else if (!scan_pass_reg) begin
                                    // Retry the whole sequence on the other mapping.
                                    scan_pass_next    = 1'b1;
                                    data_on_pin1_next = 1'b0;
                                    scan_addr_next    = i2cmws_pkg::FIRST_PROBE;
                                    phase_next        = i2cmws_pkg::PH_IDLE_READ;
                                end else begin
                                    done              = 1'b1;
                                    data_on_pin1_next = 1'b1;
                                    fail_count_next   = 32'd0;
                                    mode_next         = i2cmws_pkg::MODE_IDLE;
                                    phase_next        = i2cmws_pkg::PH_START1;
                                end
                            end
                            i2cmws_pkg::PH_SETTLE: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_IDLE;
                            end
                            i2cmws_pkg::PH_IDLE: begin
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                                phase_next   = i2cmws_pkg::PH_IDLE_READ;
                            end
                            i2cmws_pkg::PH_IDLE_READ: begin
                                rf_data_idle_next  = dsense;
                                rf_clock_idle_next = csense;
                                shift_next         = {scan_addr_reg, 1'b0};
                                bit_index_next     = 4'd0;
                                sda_low_next       = 1'b0;
                                scl_low_next       = 1'b0;
                                phase_next         = i2cmws_pkg::PH_START2;
                            end
                            default: begin
                                mode_next    = i2cmws_pkg::MODE_IDLE;
                                phase_next   = i2cmws_pkg::PH_START1;
                                sda_low_next = 1'b0;
                                scl_low_next = 1'b0;
                            end
                        endcase
                    end
                    default: begin
                        mode_next    = i2cmws_pkg::MODE_IDLE;
                        sda_low_next = 1'b0;
                        scl_low_next = 1'b0;
                    end
                endcase
            end
            i2cmws_pkg::KIND_BEGIN: begin
                if (mode_reg == i2cmws_pkg::MODE_IDLE) begin
                    if (in_count_reg == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        mode_next          = i2cmws_pkg::MODE_WRITE;
                        phase_next         = i2cmws_pkg::PH_START1;
                        bytes_left_next    = in_count_reg;
                        all_acked_next     = 1'b1;
                        holding_valid_next = 1'b0;
                        bit_index_next     = 4'd0;
                        shift_next         = {in_address_reg, 1'b0};
                    end
                end
            end
            i2cmws_pkg::KIND_DATA: begin
                if (mode_reg == i2cmws_pkg::MODE_WRITE && !holding_valid_reg &&
                    bytes_left_reg != 16'd0) begin
                    holding_byte_next  = in_data_reg;
                    holding_valid_next = 1'b1;
                end
            end
            i2cmws_pkg::KIND_SCAN: begin
                if (mode_reg == i2cmws_pkg::MODE_IDLE) begin
                    mode_next          = i2cmws_pkg::MODE_SCAN;
                    phase_next         = i2cmws_pkg::PH_SETTLE;
                    scan_pass_next     = 1'b0;
                    scan_addr_next     = i2cmws_pkg::FIRST_PROBE;
                    data_on_pin1_next  = 1'b1;
                    fail_count_next    = 32'd0;
                    rf_addr_next       = 7'd0;
                    rf_swapped_next    = 1'b0;
                    holding_valid_next = 1'b0;
                    sda_low_next       = 1'b0;
                    scl_low_next       = 1'b0;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase

        // Move the next byte into the shifter, or hold the clock low while
        // the holding register is still empty.
        if (do_load) begin
            if (holding_valid_reg) begin
                shift_next         = holding_byte_reg;
                holding_valid_next = 1'b0;
                bytes_left_next    = bytes_left_reg - 16'd1;
                bit_index_next     = 4'd0;
                sda_low_next       = ~holding_byte_reg[7];
                scl_low_next       = 1'b1;
                phase_next         = i2cmws_pkg::PH_BIT_HI;
            end else begin
                sda_low_next = 1'b0;
                scl_low_next = 1'b1;
                phase_next   = i2cmws_pkg::PH_WAIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            mode_reg          <= i2cmws_pkg::MODE_IDLE;
            phase_reg         <= i2cmws_pkg::PH_START1;
            bit_index_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            bytes_left_reg    <= 16'd0;
            all_acked_reg     <= 1'b1;
            holding_valid_reg <= 1'b0;
            data_on_pin1_reg  <= 1'b1;
            fail_count_reg    <= 32'd0;
            scan_addr_reg     <= 7'd0;
            scan_pass_reg     <= 1'b0;
            rf_addr_reg       <= 7'd0;
            rf_swapped_reg    <= 1'b0;
            rf_data_idle_reg  <= 1'b0;
            rf_clock_idle_reg <= 1'b0;
            sda_low_reg       <= 1'b0;
            scl_low_reg       <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (process) begin
                mode_reg          <= mode_next;
                phase_reg         <= phase_next;
                bit_index_reg     <= bit_index_next;
                shift_reg         <= shift_next;
                bytes_left_reg    <= bytes_left_next;
                all_acked_reg     <= all_acked_next;
                holding_valid_reg <= holding_valid_next;
                data_on_pin1_reg  <= data_on_pin1_next;
                fail_count_reg    <= fail_count_next;
                scan_addr_reg     <= scan_addr_next;
                scan_pass_reg     <= scan_pass_next;
                rf_addr_reg       <= rf_addr_next;
                rf_swapped_reg    <= rf_swapped_next;
                rf_data_idle_reg  <= rf_data_idle_next;
                rf_clock_idle_reg <= rf_clock_idle_next;
                sda_low_reg       <= sda_low_next;
                scl_low_reg       <= scl_low_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg    <= s_kind;
            in_address_reg <= s_address;
            in_count_reg   <= s_byte_count;
            in_data_reg    <= s_data_byte;
            in_pin0_reg    <= s_pin0_level;
            in_pin1_reg    <= s_pin1_level;
        end
        if (process) begin
            holding_byte_reg <= holding_byte_next;
            out_pin0_reg <= data_on_pin1_next ? scl_low_next : sda_low_next;
            out_pin1_reg <= data_on_pin1_next ? sda_low_next : scl_low_next;
            out_busy_reg <= (mode_next != i2cmws_pkg::MODE_IDLE);
            out_want_reg <= (mode_next == i2cmws_pkg::MODE_WRITE) && !holding_valid_next &&
                            (bytes_left_next != 16'd0);
            out_done_reg <= done;
            out_ok_reg   <= ok;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pin0_drive_low  = out_pin0_reg;
    assign m_pin1_drive_low  = out_pin1_reg;
    assign m_busy_res        = out_busy_reg;
    assign m_want_byte       = out_want_reg;
    assign m_done_res        = out_done_reg;
    assign m_write_ok        = out_ok_reg;
    // Status fields follow the state, which only moves when a result is made.
    assign m_nack_total      = fail_count_reg;
    assign m_found_address   = rf_addr_reg;
    assign m_pins_swapped    = rf_swapped_reg;
    assign m_data_idle_high  = rf_data_idle_reg;
    assign m_clock_idle_high = rf_clock_idle_reg;

endmodule

// ===== design/i2cmws_checker.sv =====
// ----------------------------------------------------------------------------
// I2C write master with scan: port checker
// Concurrent checks on the result channel of the top level, bound to it.
// ----------------------------------------------------------------------------
module i2cmws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_busy_res,
    input logic        m_want_byte,
    input logic        m_done_res,
    input logic        m_write_ok,
    input logic [31:0] m_nack_total
);

    // A stalled result transaction keeps its done flag and NACK total.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_done_res) &&
                                $stable(m_nack_total))
        else $error("stalled result changed");

    // A successful write is only reported on the item that finishes it.
    a_ok_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_ok |-> m_done_res)
        else $error("write_ok without done");

    // Finishing a write or scan always leaves the controller idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done while still busy");

    // A data byte can only be wanted during a transfer.
    a_want_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_want_byte |-> m_busy_res)
        else $error("byte wanted while idle");

endmodule

bind i2c_master_write_with_scan_unit i2cmws_checker u_i2cmws_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_busy_res   (m_busy_res),
    .m_want_byte  (m_want_byte),
    .m_done_res   (m_done_res),
    .m_write_ok   (m_write_ok),
    .m_nack_total (m_nack_total)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the I2C write master with scan
// Drives half-period ticks, write commands, data bytes and scan starts over
// the s_ channel while a bus responder shapes the sensed acknowledge levels.
// A cycle-free model of the controller predicts every status transaction,
// and the monitor checks each field of each m_ transaction against it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ACK_ALL  = 0;
    localparam int ACK_NONE = 1;
    localparam int ACK_COIN = 2;

    localparam logic [6:0] NO_TARGET = 7'h00;
    localparam logic [6:0] CHATTY    = 7'h7F;

    localparam int ITEMS_PER_PHASE = 40;
    localparam int MAX_SHOWN       = 20;
    localparam int LIMIT_CYCLES    = 2000000;

    typedef struct packed {
        i2cmws_pkg::kind_t kind;
        logic [6:0]  addr;
        logic [15:0] count;
        logic [7:0]  data;
        logic        p0;
        logic        p1;
    } bus_item_t;

    typedef struct packed {
        logic        p0_low;
        logic        p1_low;
        logic        busy;
        logic        want;
        logic        done;
        logic        ok;
        logic [31:0] nacks;
        logic [6:0]  found;
        logic        swapped;
        logic        d_idle;
        logic        c_idle;
    } bus_status_t;

    typedef struct packed {
        i2cmws_pkg::mode_t  mode;
        i2cmws_pkg::phase_t phase;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic [15:0] left;
        logic        acked;
        logic [7:0]  hold;
        logic        hold_full;
        logic        data_p1;
        logic [31:0] fails;
        logic [6:0]  probe;
        logic        pass2;
        logic [9:0]  flags;
        logic        sda_low;
        logic        scl_low;
    } ctrl_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = 2'd0;
    logic [6:0]  s_address = 7'd0;
    logic [15:0] s_byte_count = 16'd0;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_pin0_level = 1'b1;
    logic        s_pin1_level = 1'b1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_pin0_drive_low;
    logic        m_pin1_drive_low;
    logic        m_busy_res;
    logic        m_want_byte;
    logic        m_done_res;
    logic        m_write_ok;
    logic [31:0] m_nack_total;
    logic [6:0]  m_found_address;
    logic        m_pins_swapped;
    logic        m_data_idle_high;
    logic        m_clock_idle_high;

    i2c_master_write_with_scan_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_address         (s_address),
        .s_byte_count      (s_byte_count),
        .s_data_byte       (s_data_byte),
        .s_pin0_level      (s_pin0_level),
        .s_pin1_level      (s_pin1_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pin0_drive_low  (m_pin0_drive_low),
        .m_pin1_drive_low  (m_pin1_drive_low),
        .m_busy_res        (m_busy_res),
        .m_want_byte       (m_want_byte),
        .m_done_res        (m_done_res),
        .m_write_ok        (m_write_ok),
        .m_nack_total      (m_nack_total),
        .m_found_address   (m_found_address),
        .m_pins_swapped    (m_pins_swapped),
        .m_data_idle_high  (m_data_idle_high),
        .m_clock_idle_high (m_clock_idle_high)
    );

    bus_item_t   pending_items_q[$];
    bus_status_t expected_status_q[$];

    ctrl_state_t model_st;
    ctrl_state_t gen_st;
    bus_item_t   on_wire;
    bus_status_t predicted;
    bus_status_t observed;
    bus_status_t wanted;
    bit          item_taken = 1'b0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int ack_mode = ACK_ALL;
    int feed_pct = 100;
    logic [6:0] probe_target = NO_TARGET;
    logic       probe_pass = 1'b0;

    int error_count = 0;
    int results_seen = 0;
    int command_count = 0;
    int items_made = 0;
    int phase_start_items = 0;
    int writes_done = 0;
    int writes_failed = 0;
    int empty_writes = 0;
    int scans_done = 0;
    int scans_hit = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    function automatic ctrl_state_t reset_controller();
        ctrl_state_t s;
        s.mode      = i2cmws_pkg::MODE_IDLE;
        s.phase     = i2cmws_pkg::PH_START1;
        s.bits      = 4'd0;
        s.shreg     = 8'd0;
        s.left      = 16'd0;
        s.acked     = 1'b1;
        s.hold      = 8'd0;
        s.hold_full = 1'b0;
        s.data_p1   = 1'b1;
        s.fails     = 32'd0;
        s.probe     = 7'd0;
        s.pass2     = 1'b0;
        s.flags     = 10'd0;
        s.sda_low   = 1'b0;
        s.scl_low   = 1'b0;
        return s;
    endfunction

    function automatic ctrl_state_t drive_lines(ctrl_state_t s, logic d, logic c);
        s.sda_low = d;
        s.scl_low = c;
        return s;
    endfunction

    // Data low for a zero bit while the clock is pulled low.
    function automatic ctrl_state_t present_bit(ctrl_state_t s);
        s = drive_lines(s, ~s.shreg[7], 1'b1);
        s.phase = i2cmws_pkg::PH_BIT_HI;
        return s;
    endfunction

    // With no byte in the holding register the clock is stretched low.
    function automatic ctrl_state_t load_or_stall(ctrl_state_t s);
        if (s.hold_full) begin
            s.shreg = s.hold;
            s.hold_full = 1'b0;
            s.left = s.left - 16'd1;
            s.bits = 4'd0;
            s = present_bit(s);
        end else begin
            s = drive_lines(s, 1'b0, 1'b1);
            s.phase = i2cmws_pkg::PH_WAIT;
        end
        return s;
    endfunction

    function automatic ctrl_state_t start_probe(ctrl_state_t s);
        s.shreg = {s.probe, 1'b0};
        s.bits = 4'd0;
        s = drive_lines(s, 1'b0, 1'b0);
        s.phase = i2cmws_pkg::PH_START2;
        return s;
    endfunction

    function automatic ctrl_state_t end_scan(ctrl_state_t s);
        s.fails = 32'd0;
        s.mode = i2cmws_pkg::MODE_IDLE;
        s.phase = i2cmws_pkg::PH_START1;
        s = drive_lines(s, 1'b0, 1'b0);
        return s;
    endfunction

    function automatic void advance_controller(inout ctrl_state_t s, input bus_item_t it,
                                               output bus_status_t r);
        logic       dsense;
        logic       csense;
        logic       done;
        logic       ok;
        logic       more;
        logic [6:0] nxt;
        done = 1'b0;
        ok = 1'b0;
        case (it.kind)
            i2cmws_pkg::KIND_TICK: begin
                if (s.mode == i2cmws_pkg::MODE_IDLE) begin
                    s = drive_lines(s, 1'b0, 1'b0);
                end else begin
                    dsense = s.data_p1 ? it.p1 : it.p0;
                    csense = s.data_p1 ? it.p0 : it.p1;
                    case (s.phase)
                        i2cmws_pkg::PH_START1: begin
                            s = drive_lines(s, 1'b0, 1'b0);
                            s.phase = i2cmws_pkg::PH_START2;
                        end
                        i2cmws_pkg::PH_START2: begin
                            s = drive_lines(s, 1'b1, 1'b0);
                            s.phase = i2cmws_pkg::PH_BIT_LO;
                        end
                        i2cmws_pkg::PH_BIT_LO: s = present_bit(s);
                        i2cmws_pkg::PH_BIT_HI: begin
                            s = drive_lines(s, ~s.shreg[7], 1'b0);
                            s.shreg = {s.shreg[6:0], 1'b0};
                            s.bits = s.bits + 4'd1;
                            s.phase = (s.bits >= i2cmws_pkg::BITS_PER_BYTE) ?
                                      i2cmws_pkg::PH_ACK_LO : i2cmws_pkg::PH_BIT_LO;
                        end
                        i2cmws_pkg::PH_ACK_LO: begin
                            s = drive_lines(s, 1'b0, 1'b1);
                            s.phase = i2cmws_pkg::PH_ACK_HI;
                        end
                        i2cmws_pkg::PH_ACK_HI: begin
                            s = drive_lines(s, 1'b0, 1'b0);
                            s.phase = i2cmws_pkg::PH_ACK_READ;
                        end
                        i2cmws_pkg::PH_ACK_READ: begin
                            // A write keeps going after a NACK and only reports it at the end.
                            if (s.mode == i2cmws_pkg::MODE_WRITE) s.acked = s.acked & ~dsense;
                            else s.acked = ~dsense;
                            if (s.mode == i2cmws_pkg::MODE_WRITE && s.left != 16'd0) begin
                                s = load_or_stall(s);
                            end else begin
                                s = drive_lines(s, 1'b1, 1'b1);
                                s.phase = i2cmws_pkg::PH_STOP2;
                            end
                        end
                        i2cmws_pkg::PH_WAIT: begin
                            if (s.mode == i2cmws_pkg::MODE_WRITE && s.left != 16'd0) begin
                                s = load_or_stall(s);
                            end else begin
                                s = drive_lines(s, 1'b1, 1'b1);
                                s.phase = i2cmws_pkg::PH_STOP2;
                            end
                        end
                        i2cmws_pkg::PH_STOP2: begin
                            s = drive_lines(s, 1'b1, 1'b0);
                            s.phase = i2cmws_pkg::PH_STOP3;
                        end
                        i2cmws_pkg::PH_STOP3: begin
                            s = drive_lines(s, 1'b0, 1'b0);
                            s.phase = i2cmws_pkg::PH_FINISH;
                        end
                        i2cmws_pkg::PH_FINISH: begin
                            done = 1'b1;
                            if (s.mode == i2cmws_pkg::MODE_WRITE) begin
                                ok = s.acked;
                                if (!s.acked) s.fails = s.fails + 32'd1;
                                s.mode = i2cmws_pkg::MODE_IDLE;
                                s.phase = i2cmws_pkg::PH_START1;
                                s = drive_lines(s, 1'b0, 1'b0);
                            end else if (s.acked) begin
                                s.flags = {s.flags[9:8], s.data_p1, s.probe};
                                s = end_scan(s);
                            end else begin
                                // The two preferred probe addresses go first, then the rest
                                // of the range without repeating them.
                                more = 1'b1;
                                if (s.probe == i2cmws_pkg::FIRST_PROBE) begin
                                    nxt = i2cmws_pkg::SECOND_PROBE;
                                end else if (s.probe == i2cmws_pkg::SECOND_PROBE) begin
                                    nxt = i2cmws_pkg::RANGE_LOW;
                                end else begin
                                    nxt = s.probe + 7'd1;
                                    if (nxt == i2cmws_pkg::FIRST_PROBE)
                                        nxt = i2cmws_pkg::SECOND_PROBE + 7'd1;
                                    more = (nxt <= i2cmws_pkg::RANGE_HIGH);
                                end
                                if (more) begin
                                    done = 1'b0;
                                    s.probe = nxt;
                                    s = start_probe(s);
                                end else if (!s.pass2) begin
                                    done = 1'b0;
                                    s.pass2 = 1'b1;
                                    s.data_p1 = 1'b0;
                                    s.probe = i2cmws_pkg::FIRST_PROBE;
                                    s = drive_lines(s, 1'b0, 1'b0);
                                    s.phase = i2cmws_pkg::PH_IDLE_READ;
                                end else begin
                                    s.data_p1 = 1'b1;
                                    s = end_scan(s);
                                end
                            end
                        end
                        i2cmws_pkg::PH_SETTLE: begin
                            s = drive_lines(s, 1'b0, 1'b0);
                            s.phase = i2cmws_pkg::PH_IDLE;
                        end
                        i2cmws_pkg::PH_IDLE: begin
                            s = drive_lines(s, 1'b0, 1'b0);
                            s.phase = i2cmws_pkg::PH_IDLE_READ;
                        end
                        i2cmws_pkg::PH_IDLE_READ: begin
                            s.flags[8] = dsense;
                            s.flags[9] = csense;
                            s = start_probe(s);
                        end
                        default: begin
                            s.mode = i2cmws_pkg::MODE_IDLE;
                            s.phase = i2cmws_pkg::PH_START1;
                            s = drive_lines(s, 1'b0, 1'b0);
                        end
                    endcase
                end
            end
            i2cmws_pkg::KIND_BEGIN: begin
                if (s.mode == i2cmws_pkg::MODE_IDLE) begin
                    if (it.count == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        s.mode = i2cmws_pkg::MODE_WRITE;
                        s.phase = i2cmws_pkg::PH_START1;
                        s.left = it.count;
                        s.acked = 1'b1;
                        s.hold_full = 1'b0;
                        s.bits = 4'd0;
                        s.shreg = {it.addr, 1'b0};
                    end
                end
            end
            i2cmws_pkg::KIND_DATA: begin
                if (s.mode == i2cmws_pkg::MODE_WRITE && !s.hold_full && s.left != 16'd0) begin
                    s.hold = it.data;
                    s.hold_full = 1'b1;
                end
            end
            default: begin
                if (s.mode == i2cmws_pkg::MODE_IDLE) begin
                    s.mode = i2cmws_pkg::MODE_SCAN;
                    s.phase = i2cmws_pkg::PH_SETTLE;
                    s.pass2 = 1'b0;
                    s.probe = i2cmws_pkg::FIRST_PROBE;
                    s.data_p1 = 1'b1;
                    s.fails = 32'd0;
                    s.flags = {s.flags[9:8], 8'd0};
                    s.hold_full = 1'b0;
                    s = drive_lines(s, 1'b0, 1'b0);
                end
            end
        endcase
        r.p0_low  = s.data_p1 ? s.scl_low : s.sda_low;
        r.p1_low  = s.data_p1 ? s.sda_low : s.scl_low;
        r.busy    = (s.mode != i2cmws_pkg::MODE_IDLE);
        r.want    = (s.mode == i2cmws_pkg::MODE_WRITE && !s.hold_full && s.left != 16'd0);
        r.done    = done;
        r.ok      = ok;
        r.nacks   = s.fails;
        r.found   = s.flags[6:0];
        r.swapped = s.flags[7];
        r.d_idle  = s.flags[8];
        r.c_idle  = s.flags[9];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation, steered by a second copy of the model
    // ------------------------------------------------------------------
    function automatic bus_item_t random_item(i2cmws_pkg::kind_t k);
        bus_item_t it;
        it.kind  = k;
        it.addr  = 7'($urandom_range(0, 127));
        it.count = 16'($urandom_range(0, 65535));
        it.data  = 8'($urandom_range(0, 255));
        it.p0    = 1'($urandom_range(0, 1));
        it.p1    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_item(input bus_item_t it);
        bus_status_t       r;
        i2cmws_pkg::mode_t was;
        was = gen_st.mode;
        advance_controller(gen_st, it, r);
        pending_items_q.push_back(it);
        items_made++;
        if (it.kind != i2cmws_pkg::KIND_TICK) command_count++;
        if (r.done) begin
            if (was == i2cmws_pkg::MODE_WRITE) begin
                writes_done++;
                if (!r.ok) writes_failed++;
            end else if (was == i2cmws_pkg::MODE_SCAN) begin
                scans_done++;
                if (r.found != 7'd0) scans_hit++;
            end else begin
                empty_writes++;
            end
        end
    endtask

    // Pin levels are random except at the acknowledge sample, where the
    // responder decides what the data line reads.
    task automatic bus_tick();
        bus_item_t it;
        logic      ack;
        it = random_item(i2cmws_pkg::KIND_TICK);
        if (gen_st.mode != i2cmws_pkg::MODE_IDLE && gen_st.phase == i2cmws_pkg::PH_ACK_READ) begin
            if (gen_st.mode == i2cmws_pkg::MODE_WRITE) begin
                if (ack_mode == ACK_ALL) ack = 1'b1;
                else if (ack_mode == ACK_NONE) ack = 1'b0;
                else ack = 1'($urandom_range(0, 1));
            end else if (probe_target == CHATTY) begin
                ack = 1'($urandom_range(0, 1));
            end else begin
                ack = (probe_target != NO_TARGET && gen_st.probe == probe_target &&
                       gen_st.pass2 == probe_pass);
            end
            if (gen_st.data_p1) it.p1 = ~ack;
            else it.p0 = ~ack;
        end
        push_item(it);
    endtask

    task automatic run_until_idle();
        bus_item_t it;
        int        roll;
        while (gen_st.mode != i2cmws_pkg::MODE_IDLE) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                // Commands while busy are ignored; a data byte may still be taken.
                push_item(random_item(i2cmws_pkg::kind_t'($urandom_range(1, 3))));
            end else if (gen_st.mode == i2cmws_pkg::MODE_WRITE && !gen_st.hold_full &&
                         gen_st.left != 16'd0 && $urandom_range(0, 99) < feed_pct) begin
                push_item(random_item(i2cmws_pkg::KIND_DATA));
            end else begin
                bus_tick();
            end
        end
    endtask

    task automatic write_transfer(input logic [6:0] addr, input logic [15:0] count,
                                  input int ackm, input int feed, input int first_byte);
        bus_item_t it;
        ack_mode = ackm;
        feed_pct = feed;
        it = random_item(i2cmws_pkg::KIND_BEGIN);
        it.addr = addr;
        it.count = count;
        push_item(it);
        if (first_byte >= 0) begin
            it = random_item(i2cmws_pkg::KIND_DATA);
            it.data = first_byte[7:0];
            push_item(it);
        end
        run_until_idle();
    endtask

    task automatic scan_bus(input logic [6:0] target, input logic pass);
        probe_target = target;
        probe_pass = pass;
        push_item(random_item(i2cmws_pkg::KIND_SCAN));
        run_until_idle();
    endtask

    task automatic random_sequence();
        bus_item_t         it;
        i2cmws_pkg::kind_t k;
        int                roll;
        logic [15:0]       count;
        logic [6:0]        target;
        repeat ($urandom_range(0, 2)) bus_tick();
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            count = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(1, 2)) : 16'd3;
            roll = $urandom_range(0, 99);
            write_transfer(7'($urandom_range(0, 127)), count,
                           (roll < 55) ? ACK_ALL : (roll < 70) ? ACK_NONE : ACK_COIN,
                           ($urandom_range(0, 99) < 70) ? 90 : 15, -1);
        end else if (roll < 90) begin
            // Targets stay near the front of the probe order to keep scans short.
            roll = $urandom_range(0, 99);
            if (roll < 45) target = i2cmws_pkg::FIRST_PROBE;
            else if (roll < 70) target = i2cmws_pkg::SECOND_PROBE;
            else if (roll < 88) target = CHATTY;
            else target = i2cmws_pkg::RANGE_LOW;
            scan_bus(target, 1'b0);
        end else begin
            ack_mode = ACK_COIN;
            feed_pct = 60;
            probe_target = CHATTY;
            repeat ($urandom_range(1, 6)) begin
                k = i2cmws_pkg::kind_t'($urandom_range(0, 3));
                it = random_item(k);
                // Keep noise from opening a write that would need thousands of bytes.
                if (k == i2cmws_pkg::KIND_BEGIN && gen_st.mode == i2cmws_pkg::MODE_IDLE)
                    it.count = 16'($urandom_range(0, 3));
                push_item(it);
            end
            run_until_idle();
        end
    endtask

    task automatic drain_bus();
        while (pending_items_q.size() != 0 || s_valid || expected_status_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver, acceptance and monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            advance_controller(model_st, on_wire, predicted);
            expected_status_q.push_back(predicted);
            item_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            item_taken = 1'b0;
            if (pending_items_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                on_wire = pending_items_q.pop_front();
                s_valid      <= 1'b1;
                s_kind       <= on_wire.kind;
                s_address    <= on_wire.addr;
                s_byte_count <= on_wire.count;
                s_data_byte  <= on_wire.data;
                s_pin0_level <= on_wire.p0;
                s_pin1_level <= on_wire.p1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, what, got, exp_val);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_status_q.size() == 0) begin
                report_mismatch("status transaction with nothing pending", 32'd0, 32'd0);
            end else begin
                wanted = expected_status_q.pop_front();
                observed.p0_low  = m_pin0_drive_low;
                observed.p1_low  = m_pin1_drive_low;
                observed.busy    = m_busy_res;
                observed.want    = m_want_byte;
                observed.done    = m_done_res;
                observed.ok      = m_write_ok;
                observed.nacks   = m_nack_total;
                observed.found   = m_found_address;
                observed.swapped = m_pins_swapped;
                observed.d_idle  = m_data_idle_high;
                observed.c_idle  = m_clock_idle_high;
                if (observed.p0_low !== wanted.p0_low)
                    report_mismatch("pin0_drive_low", 32'(observed.p0_low),
                                    32'(wanted.p0_low));
                if (observed.p1_low !== wanted.p1_low)
                    report_mismatch("pin1_drive_low", 32'(observed.p1_low),
                                    32'(wanted.p1_low));
                if (observed.busy !== wanted.busy)
                    report_mismatch("busy_res", 32'(observed.busy), 32'(wanted.busy));
                if (observed.want !== wanted.want)
                    report_mismatch("want_byte", 32'(observed.want), 32'(wanted.want));
                if (observed.done !== wanted.done)
                    report_mismatch("done_res", 32'(observed.done), 32'(wanted.done));
                if (observed.ok !== wanted.ok)
                    report_mismatch("write_ok", 32'(observed.ok), 32'(wanted.ok));
                if (observed.nacks !== wanted.nacks)
                    report_mismatch("nack_total", observed.nacks, wanted.nacks);
                if (observed.found !== wanted.found)
                    report_mismatch("found_address", 32'(observed.found), 32'(wanted.found));
                if (observed.swapped !== wanted.swapped)
                    report_mismatch("pins_swapped", 32'(observed.swapped),
                                    32'(wanted.swapped));
                if (observed.d_idle !== wanted.d_idle)
                    report_mismatch("data_idle_high", 32'(observed.d_idle),
                                    32'(wanted.d_idle));
                if (observed.c_idle !== wanted.c_idle)
                    report_mismatch("clock_idle_high", 32'(observed.c_idle),
                                    32'(wanted.c_idle));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        model_st = reset_controller();
        gen_st = reset_controller();
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed part: idle items, empty write, extremes, busy and stray commands.
        bus_tick();
        bus_tick();
        push_item(random_item(i2cmws_pkg::KIND_DATA));
        write_transfer(7'h7F, 16'd0, ACK_ALL, 100, -1);
        write_transfer(7'h7F, 16'd1, ACK_ALL, 100, 0);
        write_transfer(7'h00, 16'd1, ACK_NONE, 100, 255);
        begin : busy_commands
            bus_item_t it;
            ack_mode = ACK_COIN;
            feed_pct = 30;
            it = random_item(i2cmws_pkg::KIND_BEGIN);
            it.addr = 7'h55;
            it.count = 16'd1;
            push_item(it);
            it.addr = 7'h7F;
            it.count = 16'hFFFF;
            push_item(it);
            it.count = 16'd0;
            push_item(it);
            push_item(random_item(i2cmws_pkg::KIND_SCAN));
            push_item(random_item(i2cmws_pkg::KIND_DATA));
            push_item(random_item(i2cmws_pkg::KIND_DATA));
            run_until_idle();
        end
        // Walks both preferred probes before reaching the low end of the range.
        scan_bus(i2cmws_pkg::RANGE_LOW, 1'b0);
        drain_bus();

        // Random part in four idling phases; each phase drains before the next.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            phase_start_items = items_made;
            while (items_made - phase_start_items < ITEMS_PER_PHASE) random_sequence();
            drain_bus();
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d items (%0d commands) and %0d status transactions over four idling phases.",
                 items_made, command_count, results_seen);
        $display("Writes: %0d finished (%0d with a NACK), %0d empty; scans: %0d, %0d answered.",
                 writes_done, writes_failed, empty_writes, scans_done, scans_hit);
        if (error_count == 0 && expected_status_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(10 * LIMIT_CYCLES);
        $display("Timeout with %0d status transactions outstanding.", expected_status_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
